/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* rtl/core/rsld_pkg.sv */
// ----------------------------------------------------------------------------
// rsld_pkg
// Types and constants shared by the safe longitudinal distance core.
// ----------------------------------------------------------------------------
package rsld_pkg;

   localparam int SPD_W   = 16;           // speed, time and acceleration words
   localparam int NUM_W   = 37;           // divider dividend / quotient width
   localparam int DEN_W   = 16;           // divider divisor width
   localparam int LANES   = 3;
   localparam int LANE_TRAVEL = 0;
   localparam int LANE_REAR   = 1;
   localparam int LANE_FRONT  = 2;
   localparam int PREP_STAGES = 5;

   localparam logic [31:0] GAP_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] GAP_MIN = 32'h8000_0000;

   typedef enum logic [2:0] {
      CSR_REAR_SPEED_CAP   = 3'd0,
      CSR_REACTION_TIME    = 3'd1,
      CSR_REAR_ACCEL_LIMIT = 3'd2,
      CSR_REAR_BRAKE_MIN   = 3'd3,
      CSR_FRONT_BRAKE_MAX  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [SPD_W-1:0] rear_speed_cap;
      logic [SPD_W-1:0] reaction_time;
      logic [SPD_W-1:0] rear_accel_limit;
      logic [SPD_W-1:0] rear_brake_min;
      logic [SPD_W-1:0] front_brake_max;
   } cfg_type;

   typedef struct packed {
      logic [15:0] front_speed;
      logic [15:0] rear_speed;
   } req_type;

   typedef struct packed {
      logic signed [31:0] safe_gap;
      logic               gap_error;
   } rsp_type;

   typedef logic [LANES-1:0][NUM_W-1:0] lane_num_type;
   typedef logic [LANES-1:0][DEN_W-1:0] lane_den_type;

   typedef struct packed {
      lane_num_type num;
      lane_den_type den;
   } div_item_type;

   typedef struct packed {
      lane_num_type quo;
   } quo_type;

endpackage

/* rtl/core/rss_safe_longitudinal_distance_core.sv */
// ----------------------------------------------------------------------------
// rss_safe_longitudinal_distance_core
// Minimum safe following gap from front and rear speeds, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   dir   handshake          payload
//  req       in    req_valid/ready    req_type  (front_speed, rear_speed)
//  rsp       out   rsp_valid/ready    rsp_type  (safe_gap, gap_error)
//  csr       in    csr_we             csr_index, csr_wdata (16 bit)
//
//  One word accepted per cycle when the output does not stall; five front-end stages,
//  37 divider stages (one quotient bit each), one output register.
//  Reset is synchronous and clears valid bits and loads register defaults.
//  A stall holds every full stage with no empty stage ahead; empty stages keep filling.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rss_safe_longitudinal_distance_core
   import rsld_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type      cfg_ff;
   logic         prep_valid, prep_ready, div_valid, div_ready;
   div_item_type prep_data;
   quo_type      div_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rear_speed_cap   <= 16'd8960;
         cfg_ff.reaction_time    <= 16'd4096;
         cfg_ff.rear_accel_limit <= 16'd6144;
         cfg_ff.rear_brake_min   <= 16'd8192;
         cfg_ff.front_brake_max  <= 16'd16384;
      end else if (csr_we) begin
         case (csr_index)
            CSR_REAR_SPEED_CAP:   cfg_ff.rear_speed_cap   <= csr_wdata;
            CSR_REACTION_TIME:    cfg_ff.reaction_time    <= csr_wdata;
            CSR_REAR_ACCEL_LIMIT: cfg_ff.rear_accel_limit <= csr_wdata;
            CSR_REAR_BRAKE_MIN:   cfg_ff.rear_brake_min   <= csr_wdata;
            CSR_FRONT_BRAKE_MAX:  cfg_ff.front_brake_max  <= csr_wdata;
            default: ;
         endcase
      end
   end

   rsld_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (prep_valid),
      .out_ready (prep_ready),
      .out_data  (prep_data)
   );

   rsld_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_data   (prep_data),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data)
   );

   rsld_sat u_sat (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_data   (div_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   `ASSERT_IMPLIES(a_zero_rear_brake, clock, reset,
      rsp_valid && cfg_ff.rear_brake_min == '0,
      rsp_data.gap_error && rsp_data.safe_gap == GAP_MAX)

   `ASSERT_IMPLIES(a_zero_front_brake, clock, reset,
      rsp_valid && cfg_ff.rear_brake_min != '0 && cfg_ff.front_brake_max == '0,
      rsp_data.gap_error && rsp_data.safe_gap == GAP_MIN)

   `ASSERT_NEXT(a_div_to_rsp, clock, reset, div_valid && div_ready, rsp_valid)

endmodule

/* rtl/core/rsld_prep.sv */
// ----------------------------------------------------------------------------
// rsld_prep
// Five-stage front end: products, cap test, numerators, final speed squared,
// and rounded dividends for the three distance terms.
// ----------------------------------------------------------------------------
module rsld_prep
   import rsld_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_type      in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output div_item_type out_data
);

   logic [PREP_STAGES-1:0] v_ff;
   logic [PREP_STAGES:0]   rdy;
   logic [PREP_STAGES-1:0] src_v;

   // stage 1
   logic [15:0] capm_ff, capm_in, vr1_ff, dv1_ff, dv1_in;
   logic [31:0] ta1_ff, ta1_in, capt1_ff, capt1_in, dv2_1_ff, dv2_1_in;
   logic [31:0] vrt1_ff, vrt1_in, vf2_1_ff, vf2_1_in, tt1_ff, tt1_in;
   // stage 2
   logic        hit2_ff, hit2_in;
   logic [47:0] capta2_ff, capta2_in, att2_ff, att2_in;
   logic [31:0] ta2_ff, dv2_2_ff, vrt2_ff, vf2_2_ff;
   logic [15:0] capm2_ff, vr2_ff;
   // stage 3
   logic [NUM_W-1:0] nt3_ff, nt3_in, nf3_ff, nf3_in;
   logic [DEN_W-1:0] dt3_ff, dt3_in;
   logic [30:0]      va3_ff, va3_in;
   // stage 4
   logic [61:0]      vsq4_ff, vsq4_in;
   logic [NUM_W-1:0] nt4_ff, nf4_ff;
   logic [DEN_W-1:0] dt4_ff;
   // stage 5
   logic [NUM_W-1:0] nr5_ff, nr5_in, nt5_ff, nf5_ff;
   logic [DEN_W-1:0] dt5_ff;

   logic [55:0] num_hit;
   logic [56:0] sum_hit;
   logic [49:0] sum_else;
   logic [35:0] nf_sum;
   logic [62:0] nr_sum;

   assign src_v = {v_ff[PREP_STAGES-2:0], in_valid};

   always_comb begin
      rdy[PREP_STAGES] = out_ready;
      for (int i = PREP_STAGES - 1; i >= 0; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
   end

   assign in_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < PREP_STAGES; i++) begin
            if (rdy[i]) begin
               v_ff[i] <= src_v[i];
            end
         end
      end
   end

   // stage 1: raise the cap to the current speed, first products
   always_comb begin
      capm_in  = (cfg.rear_speed_cap < in_data.rear_speed) ? in_data.rear_speed
                                                            : cfg.rear_speed_cap;
      dv1_in   = capm_in - in_data.rear_speed;
      ta1_in   = {16'b0, cfg.reaction_time} * {16'b0, cfg.rear_accel_limit};
      capt1_in = {16'b0, capm_in} * {16'b0, cfg.reaction_time};
      dv2_1_in = {16'b0, dv1_in} * {16'b0, dv1_in};
      vrt1_in  = {16'b0, in_data.rear_speed} * {16'b0, cfg.reaction_time};
      vf2_1_in = {16'b0, in_data.front_speed} * {16'b0, in_data.front_speed};
      tt1_in   = {16'b0, cfg.reaction_time} * {16'b0, cfg.reaction_time};
   end

   always_ff @(posedge clock) begin
      if (rdy[0] && src_v[0]) begin
         capm_ff  <= capm_in;
         vr1_ff   <= in_data.rear_speed;
         dv1_ff   <= dv1_in;
         ta1_ff   <= ta1_in;
         capt1_ff <= capt1_in;
         dv2_1_ff <= dv2_1_in;
         vrt1_ff  <= vrt1_in;
         vf2_1_ff <= vf2_1_in;
         tt1_ff   <= tt1_in;
      end
   end

   // stage 2: does the rear vehicle reach its cap within the response time
   always_comb begin
      hit2_in   = (cfg.rear_accel_limit != '0) && (ta1_ff >= {1'b0, dv1_ff, 15'b0});
      capta2_in = {16'b0, capt1_ff} * {32'b0, cfg.rear_accel_limit};
      att2_in   = {16'b0, tt1_ff} * {32'b0, cfg.rear_accel_limit};
   end

   always_ff @(posedge clock) begin
      if (rdy[1] && src_v[1]) begin
         hit2_ff   <= hit2_in;
         capta2_ff <= capta2_in;
         att2_ff   <= att2_in;
         ta2_ff    <= ta1_ff;
         dv2_2_ff  <= dv2_1_ff;
         vrt2_ff   <= vrt1_ff;
         vf2_2_ff  <= vf2_1_ff;
         capm2_ff  <= capm_ff;
         vr2_ff    <= vr1_ff;
      end
   end

   // stage 3: travel dividend, speed after response, front stop dividend
   always_comb begin
      num_hit  = {capta2_ff, 8'b0} - {2'b0, dv2_2_ff, 22'b0};
      sum_hit  = {1'b0, num_hit} + {22'b0, cfg.rear_accel_limit, 19'b0};
      sum_else = {2'b0, vrt2_ff, 16'b0} + {2'b0, att2_ff} + 50'h000_0800_0000;
      nf_sum   = {1'b0, vf2_2_ff, 3'b0} + {20'b0, cfg.front_brake_max};
      nf3_in   = {2'b0, nf_sum[35:1]};
      if (hit2_ff) begin
         nt3_in = sum_hit[56:20];
         dt3_in = cfg.rear_accel_limit;
         va3_in = {capm2_ff, 15'b0};
      end else begin
         // no division needed: pass the rounded travel through a divide by one
         nt3_in = {15'b0, sum_else[49:28]};
         dt3_in = 16'd1;
         va3_in = {vr2_ff, 15'b0} + ta2_ff[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2] && src_v[2]) begin
         nt3_ff <= nt3_in;
         nf3_ff <= nf3_in;
         dt3_ff <= dt3_in;
         va3_ff <= va3_in;
      end
   end

   // stage 4: square the speed after response
   assign vsq4_in = {31'b0, va3_ff} * {31'b0, va3_ff};

   always_ff @(posedge clock) begin
      if (rdy[3] && src_v[3]) begin
         vsq4_ff <= vsq4_in;
         nt4_ff  <= nt3_ff;
         nf4_ff  <= nf3_ff;
         dt4_ff  <= dt3_ff;
      end
   end

   // stage 5: fold rounding and the 2^28 scale into the rear stop dividend
   always_comb begin
      nr_sum = {1'b0, vsq4_ff} + {20'b0, cfg.rear_brake_min, 27'b0};
      nr5_in = {2'b0, nr_sum[62:28]};
   end

   always_ff @(posedge clock) begin
      if (rdy[4] && src_v[4]) begin
         nr5_ff <= nr5_in;
         nt5_ff <= nt4_ff;
         nf5_ff <= nf4_ff;
         dt5_ff <= dt4_ff;
      end
   end

   assign out_valid = v_ff[PREP_STAGES-1];

   always_comb begin
      out_data                  = '0;
      out_data.num[LANE_TRAVEL] = nt5_ff;
      out_data.den[LANE_TRAVEL] = dt5_ff;
      out_data.num[LANE_REAR]   = nr5_ff;
      out_data.den[LANE_REAR]   = cfg.rear_brake_min;
      out_data.num[LANE_FRONT]  = nf5_ff;
      out_data.den[LANE_FRONT]  = cfg.front_brake_max;
   end

endmodule

/* rtl/core/rsld_div.sv */
// ----------------------------------------------------------------------------
// rsld_div
// Pipelined restoring divider, three lanes in lockstep, one quotient bit
// per stage.
// ----------------------------------------------------------------------------
module rsld_div
   import rsld_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  div_item_type in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output quo_type      out_data
);

   logic [NUM_W-1:0] v_ff;
   logic [NUM_W:0]   rdy;
   lane_num_type     work_ff [NUM_W];
   lane_den_type     rem_ff  [NUM_W];
   lane_den_type     den_ff  [NUM_W];

   assign rdy[NUM_W] = out_ready;
   assign in_ready   = rdy[0];

   for (genvar k = 0; k < NUM_W; k++) begin : gen_step
      logic         src_v;
      lane_num_type src_work, work_in;
      lane_den_type src_rem, src_den, rem_in;

      if (k == 0) begin : gen_head
         assign src_v    = in_valid;
         assign src_work = in_data.num;
         assign src_rem  = '0;
         assign src_den  = in_data.den;
      end else begin : gen_body
         assign src_v    = v_ff[k-1];
         assign src_work = work_ff[k-1];
         assign src_rem  = rem_ff[k-1];
         assign src_den  = den_ff[k-1];
      end

      assign rdy[k] = !v_ff[k] || rdy[k+1];

      // shift in the next dividend bit, subtract when it fits
      always_comb begin
         logic [DEN_W:0] part;
         logic           qbit;
         for (int l = 0; l < LANES; l++) begin
            part = {src_rem[l], src_work[l][NUM_W-1]};
            qbit = (part >= {1'b0, src_den[l]});
            if (qbit) begin
               part = part - {1'b0, src_den[l]};
            end
            rem_in[l]  = part[DEN_W-1:0];
            work_in[l] = {src_work[l][NUM_W-2:0], qbit};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            v_ff[k] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k] && src_v) begin
            work_ff[k] <= work_in;
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= src_den;
         end
      end
   end

   assign out_valid    = v_ff[NUM_W-1];
   assign out_data.quo = work_ff[NUM_W-1];

endmodule

/* rtl/core/rsld_sat.sv */
// ----------------------------------------------------------------------------
// rsld_sat
// Output stage: combine the three distance terms, saturate, flag errors.
// ----------------------------------------------------------------------------
module rsld_sat
   import rsld_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    in_valid,
   output logic    in_ready,
   input  quo_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic        valid_ff;
   rsp_type     data_ff, data_in;
   logic [38:0] sum;
   logic [7:0]  top;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      sum = {2'b0, in_data.quo[LANE_TRAVEL]} + {2'b0, in_data.quo[LANE_REAR]}
          - {2'b0, in_data.quo[LANE_FRONT]};
      top = sum[38:31];
      data_in.safe_gap  = sum[31:0];
      data_in.gap_error = 1'b0;
      if (cfg.rear_brake_min == '0) begin
         data_in.safe_gap  = GAP_MAX;
         data_in.gap_error = 1'b1;
      end else if (cfg.front_brake_max == '0) begin
         data_in.safe_gap  = GAP_MIN;
         data_in.gap_error = 1'b1;
      end else if (top != '0 && top != '1) begin
         // clamp toward the sign of the wide sum
         data_in.safe_gap  = sum[38] ? GAP_MIN : GAP_MAX;
         data_in.gap_error = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the safe longitudinal gap core: speed pairs go in
// over valid/ready, each gap is predicted in fixed point and compared with the
// core's output under several register settings and handshake idle patterns.
// ----------------------------------------------------------------------------

class gap_scoreboard;
   rsld_pkg::cfg_type    regs;
   rsld_pkg::rsp_type    gap_q[$];
   int                   errors;
   int                   pairs_seen;
   int                   gaps_checked;
   int                   cap_hits;

   function new();
      reset_regs();
      errors = 0;
      pairs_seen = 0;
      gaps_checked = 0;
      cap_hits = 0;
   endfunction

   function void reset_regs();
      regs.rear_speed_cap   = 16'd8960;
      regs.reaction_time    = 16'd4096;
      regs.rear_accel_limit = 16'd6144;
      regs.rear_brake_min   = 16'd8192;
      regs.front_brake_max  = 16'd16384;
   endfunction

   function void write_reg(rsld_pkg::csr_index_type idx, logic [15:0] val);
      case (idx)
         rsld_pkg::CSR_REAR_SPEED_CAP:   regs.rear_speed_cap   = val;
         rsld_pkg::CSR_REACTION_TIME:    regs.reaction_time    = val;
         rsld_pkg::CSR_REAR_ACCEL_LIMIT: regs.rear_accel_limit = val;
         rsld_pkg::CSR_REAR_BRAKE_MIN:   regs.rear_brake_min   = val;
         rsld_pkg::CSR_FRONT_BRAKE_MAX:  regs.front_brake_max  = val;
         default: ;
      endcase
   endfunction

   // response travel + rear stop - front stop, each rounded once to 2^-8 m
   function rsld_pkg::rsp_type safe_gap_of(rsld_pkg::req_type p);
      longint unsigned vf, vr, cap, t, a, bmin, bmax;
      longint unsigned travel, vafter, rstop, fstop, dv, num, den;
      longint          sum;
      rsld_pkg::rsp_type g;
      vf = p.front_speed;
      vr = p.rear_speed;
      cap = regs.rear_speed_cap;
      t = regs.reaction_time;
      a = regs.rear_accel_limit;
      bmin = regs.rear_brake_min;
      bmax = regs.front_brake_max;
      g.gap_error = 1'b0;
      if (bmin == 0) begin
         g.safe_gap = rsld_pkg::GAP_MAX;
         g.gap_error = 1'b1;
         return g;
      end
      if (bmax == 0) begin
         g.safe_gap = rsld_pkg::GAP_MIN;
         g.gap_error = 1'b1;
         return g;
      end
      if (cap < vr) cap = vr;
      dv = cap - vr;
      if (a != 0 && t * a >= (dv << 15)) begin
         cap_hits++;
         num = ((cap * t * a) << 8) - ((dv * dv) << 22);
         den = a << 20;
         travel = (num + (den >> 1)) / den;
         vafter = cap << 15;
      end else begin
         num = ((vr * t) << 16) + a * t * t;
         travel = (num + (64'd1 << 27)) >> 28;
         vafter = (vr << 15) + a * t;
      end
      den = bmin << 28;
      rstop = (vafter * vafter + (den >> 1)) / den;
      den = bmax << 1;
      fstop = (((vf * vf) << 3) + (den >> 1)) / den;
      sum = longint'(travel) + longint'(rstop) - longint'(fstop);
      if (sum > 64'sd2147483647) begin
         sum = 64'sd2147483647;
         g.gap_error = 1'b1;
      end else if (sum < -64'sd2147483648) begin
         sum = -64'sd2147483648;
         g.gap_error = 1'b1;
      end
      g.safe_gap = sum[31:0];
      return g;
   endfunction

   function void note_pair(rsld_pkg::req_type p);
      pairs_seen++;
      gap_q.push_back(safe_gap_of(p));
   endfunction

   function void check_gap(rsld_pkg::rsp_type got);
      rsld_pkg::rsp_type want;
      if (gap_q.size() == 0) begin
         $error("unexpected gap word: safe_gap %0d gap_error %0b",
                got.safe_gap, got.gap_error);
         errors++;
         return;
      end
      want = gap_q.pop_front();
      gaps_checked++;
      if (got.safe_gap !== want.safe_gap) begin
         $error("safe_gap: expected %0d, got %0d", want.safe_gap, got.safe_gap);
         errors++;
      end
      if (got.gap_error !== want.gap_error) begin
         $error("gap_error: expected %0b, got %0b", want.gap_error, got.gap_error);
         errors++;
      end
   endfunction
endclass

module tb;
   import rsld_pkg::*;

   localparam int LATENCY = 43;
   localparam int CYCLE_LIMIT = 400000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   gap_scoreboard board;
   req_type       pair_q[$];
   int            send_idle_pct;
   int            recv_idle_pct;
   bit            hold_req;
   int            hold_left;
   int            cycles;

   rss_safe_longitudinal_distance_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // sender: note the accepted word, then offer the next one or idle
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_pair(req_data);
         if (!req_valid || req_ready) begin
            if (pair_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pair_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: check the word, then pick ready; a hold-off request wins
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) board.check_gap(rsp_data);
         if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 400;
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic write_regs(logic [15:0] cap, logic [15:0] t, logic [15:0] a,
                             logic [15:0] bmin, logic [15:0] bmax);
      logic [15:0] vals[5];
      csr_index_type idx;
      vals = '{cap, t, a, bmin, bmax};
      for (int i = 0; i < 5; i++) begin
         idx = csr_index_type'(i);
         @(posedge clock);
         csr_we <= 1'b1;
         csr_index <= idx;
         csr_wdata <= vals[i];
         board.write_reg(idx, vals[i]);
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic push_pair(logic [15:0] front, logic [15:0] rear);
      req_type p;
      p.front_speed = front;
      p.rear_speed = rear;
      pair_q.push_back(p);
   endtask

   // a quarter full range, a quarter around the cap, the rest at lower speeds
   task automatic push_random(int n);
      logic [15:0] cap;
      for (int i = 0; i < n; i++) begin
         cap = board.regs.rear_speed_cap;
         case ($urandom_range(3))
            0: push_pair(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)));
            1: push_pair(16'($urandom_range(16'h4000)), 16'($urandom_range(16'h4000)));
            2: push_pair(16'($urandom_range(16'hFFFF)),
                         16'(cap - 16'($urandom_range(2048)) + 16'd1024));
            default: push_pair(16'($urandom_range(16'h2000)), 16'($urandom_range(cap)));
         endcase
      end
   endtask

   task automatic drain();
      while (pair_q.size() != 0 || req_valid || board.gap_q.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   initial begin
      board = new();
      cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_REAR_SPEED_CAP;
      csr_wdata = '0;
      hold_req = 1'b0;
      hold_left = 0;
      send_idle_pct = 11;
      recv_idle_pct = 69;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // defaults: extremes, cap hit and no cap hit
      push_pair(16'h0000, 16'h0000);
      push_pair(16'hFFFF, 16'hFFFF);
      push_pair(16'hFFFF, 16'h0000);
      push_pair(16'h0000, 16'hFFFF);
      push_pair(16'h1000, 16'd8960);
      push_pair(16'h1000, 16'd8000);
      push_pair(16'h1000, 16'd8192);
      push_pair(16'h2000, 16'd100);
      push_pair(16'hAAAA, 16'h5555);
      push_pair(16'h5555, 16'hAAAA);
      drain();

      for (int s = 0; s < 9; s++) begin
         if (s < 3) begin
            send_idle_pct = 11;
            recv_idle_pct = 69;
         end else if (s < 6) begin
            send_idle_pct = 69;
            recv_idle_pct = 11;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (s)
            0: write_regs(16'd8960, 16'd4096, 16'd6144, 16'd8192, 16'd16384);
            1: write_regs(16'd8960, 16'd4096, 16'd0, 16'd8192, 16'd16384);
            2: write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            3: write_regs(16'd5000, 16'd0, 16'd4096, 16'd0, 16'd0);
            4: write_regs(16'd0, 16'd8192, 16'd2048, 16'd4096, 16'd0);
            5: write_regs(16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'd1);
            default: write_regs(16'($urandom_range(16'hFFFF)),
                                16'($urandom_range(16'hFFFF)),
                                16'($urandom_range(16'hFFFF)),
                                16'($urandom_range(1, 16'hFFFF)),
                                16'($urandom_range(1, 16'hFFFF)));
         endcase
         if (s == 5) begin
            // tiny braking values: drive the sum past both rails
            push_pair(16'h0000, 16'hFFFF);
            push_pair(16'hFFFF, 16'h0000);
         end
         if (s == 6) hold_req = 1'b1;
         push_random(120);
         drain();
      end

      $display("covered %0d speed pairs, %0d gaps checked, %0d with the cap reached",
               board.pairs_seen, board.gaps_checked, board.cap_hits);
      $display("settings: defaults, zero accel, all-ones, zero braking, random");
      if (board.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/rsld_pkg.sv
rtl/core/rsld_prep.sv
rtl/core/rsld_div.sv
rtl/core/rsld_sat.sv
rtl/core/rss_safe_longitudinal_distance_core.sv
test/tb.sv
